// ===== src/bsrc_pkg.sv =====
// Shared types and constants for the banker's safety request checker.
`default_nettype none

package bsrc_pkg;

   // Fixed port layout
   localparam int AMOUNT_FIELDS  = 4;
   localparam int AMOUNT_FIELD_W = 8;
   localparam int PROCESS_W      = 3;
   localparam int OP_W           = 2;
   localparam int STATUS_W       = 2;
   localparam int REQ_DATA_W     = 40;
   localparam int RSP_DATA_W     = 8;
   localparam int CSR_INDEX_W    = 1;
   localparam int CSR_DATA_W     = 4;
   localparam int PROCS_REG_W    = 4;
   localparam int RES_REG_W      = 3;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_PROCESSES = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_RESOURCES = 1'd1;

   // Reset values of the registers
   localparam logic [PROCS_REG_W-1:0] PROCS_RESET = 4'd8;
   localparam logic [RES_REG_W-1:0]   RES_RESET   = 3'd4;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD_MAX   = 2'd0,
      OP_LOAD_ALLOC = 2'd1,
      OP_SET_AVAIL  = 2'd2,
      OP_REQUEST    = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_LOADED  = 2'd0,
      STAT_GRANTED = 2'd1,
      STAT_EXCEEDS = 2'd2,
      STAT_UNSAFE  = 2'd3
   } status_type;

   // Command issued to every resource lane
   typedef enum logic [2:0] {
      LOP_NONE,
      LOP_LOAD_MAX,
      LOP_LOAD_ALLOC,
      LOP_LOAD_AVAIL,
      LOP_GRANT,
      LOP_ROLLBACK,
      LOP_RELEASE
   } lane_op_type;

   // What one lane reports for the addressed row
   typedef struct packed {
      logic exceeds;  // request amount above need or available
      logic fits;     // need fits the work vector
   } lane_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_DECIDE,
      ST_RESULT
   } state_type;

endpackage

`default_nettype wire

// ===== src/bsrc_lane.sv =====
// One resource column: max/alloc column, available and work counters, compares.
`default_nettype none

module bsrc_lane #(
   parameter int PROCESSES   = 8,
   parameter int AMOUNT_BITS = 8
) (
   input  wire                          clock,
   input  wire                          reset,
   input  bsrc_pkg::lane_op_type        lane_op,
   input  wire [$clog2(PROCESSES)-1:0]  row,
   input  wire [AMOUNT_BITS-1:0]        amount,
   input  wire                          col_active,
   output bsrc_pkg::lane_stat_type      stat
);

   localparam int AW = AMOUNT_BITS;
   // available plus every allocation never exceeds this width
   localparam int WW = AW + $clog2(PROCESSES + 1);

   logic [AW-1:0]      max_ff   [PROCESSES];
   logic [AW-1:0]      alloc_ff [PROCESSES];
   logic [AW-1:0]      avail_ff;
   logic [WW-1:0]      work_ff;

   logic [AW-1:0]      max_rd;
   logic [AW-1:0]      alloc_rd;
   logic signed [AW:0] need;

   // Row read at the single sequencer-chosen address
   assign max_rd   = max_ff[row];
   assign alloc_rd = alloc_ff[row];
   assign need     = $signed({1'b0, max_rd}) - $signed({1'b0, alloc_rd});

   assign stat.exceeds = ($signed({1'b0, amount}) > need) || (amount > avail_ff);
   assign stat.fits    = need[AW] || (WW'(need[AW-1:0]) <= work_ff);

   // Table and available updates
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PROCESSES; i++) begin
            max_ff[i]   <= '0;
            alloc_ff[i] <= '0;
         end
         avail_ff <= '0;
      end else begin
         case (lane_op)
            bsrc_pkg::LOP_LOAD_MAX:   max_ff[row]   <= amount;
            bsrc_pkg::LOP_LOAD_ALLOC: alloc_ff[row] <= amount;
            bsrc_pkg::LOP_LOAD_AVAIL: avail_ff      <= amount;
            bsrc_pkg::LOP_GRANT: begin
               if (col_active) begin
                  alloc_ff[row] <= alloc_rd + amount;
                  avail_ff      <= avail_ff - amount;
               end
            end
            bsrc_pkg::LOP_ROLLBACK: begin
               if (col_active) begin
                  alloc_ff[row] <= alloc_rd - amount;
                  avail_ff      <= avail_ff + amount;
               end
            end
            default: ;
         endcase
      end
   end

   // Work vector: starts at the post-grant available, grows on release
   always_ff @(posedge clock) begin
      case (lane_op)
         bsrc_pkg::LOP_GRANT:   work_ff <= WW'(avail_ff - amount);
         bsrc_pkg::LOP_RELEASE: work_ff <= work_ff + WW'(alloc_rd);
         default: ;
      endcase
   end

endmodule

`default_nettype wire

// ===== src/bsrc_ctrl.sv =====
// Sequencer: handshakes, registers, lane merge and the safety scan over processes.
`default_nettype none

module bsrc_ctrl #(
   parameter int PROCESSES   = 8,
   parameter int RESOURCES   = 4,
   parameter int AMOUNT_BITS = 8
) (
   input  wire                                       clock,
   input  wire                                       reset,
   // input channel, unpacked
   input  wire                                       req_tvalid,
   output logic                                      req_tready,
   input  wire [bsrc_pkg::OP_W-1:0]                  req_op,
   input  wire [bsrc_pkg::PROCESS_W-1:0]             req_process,
   input  wire [bsrc_pkg::AMOUNT_FIELDS-1:0][bsrc_pkg::AMOUNT_FIELD_W-1:0] req_amount,
   // result channel
   output logic                                      rsp_tvalid,
   input  wire                                       rsp_tready,
   output bsrc_pkg::status_type                      rsp_status,
   // configuration
   input  wire                                       csr_wr_en,
   input  wire [bsrc_pkg::CSR_INDEX_W-1:0]           csr_index,
   input  wire [bsrc_pkg::CSR_DATA_W-1:0]            csr_wdata,
   // lanes
   output bsrc_pkg::lane_op_type                     lane_op,
   output logic [$clog2(PROCESSES)-1:0]              lane_row,
   output logic [RESOURCES-1:0][AMOUNT_BITS-1:0]     lane_amt,
   output logic [RESOURCES-1:0]                      lane_active,
   input  bsrc_pkg::lane_stat_type [RESOURCES-1:0]   lane_stat
);

   localparam int PW  = $clog2(PROCESSES);
   localparam int AW  = AMOUNT_BITS;
   localparam int NPW = $clog2(PROCESSES + 1);

   bsrc_pkg::state_type                 state_ff, state_in;
   logic [bsrc_pkg::PROCS_REG_W-1:0]    procs_ff;
   logic [bsrc_pkg::RES_REG_W-1:0]      res_ff;
   logic [PW-1:0]                       row_ff, row_in;
   logic [PW-1:0]                       ptr_ff, ptr_in;
   logic [PROCESSES-1:0]                done_ff, done_in;
   logic                                found_ff, found_in;
   logic [RESOURCES-1:0][AW-1:0]        amt_ff, amt_in;
   bsrc_pkg::status_type                status_ff, status_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   bsrc_pkg::status_type                rsp_status_ff, rsp_status_in;

   logic [NPW-1:0]                      np;
   logic [bsrc_pkg::RES_REG_W-1:0]      nr;
   logic [PW-1:0]                       req_row;
   logic                                req_in_range;
   logic                                slot_free;
   logic                                accept;
   logic                                rsp_load;
   bsrc_pkg::status_type                rsp_new;
   logic                                any_exceed;
   logic                                fits_all;
   logic                                hit;
   logic [RESOURCES-1:0][AW-1:0]        req_amt;

   // Clamp the configured counts into their legal ranges
   always_comb begin
      if (procs_ff == '0)
         np = NPW'(1);
      else if (32'(procs_ff) > 32'(PROCESSES))
         np = NPW'(PROCESSES);
      else
         np = NPW'(procs_ff);
      if (res_ff == '0)
         nr = bsrc_pkg::RES_REG_W'(1);
      else if (32'(res_ff) > 32'(RESOURCES))
         nr = bsrc_pkg::RES_REG_W'(RESOURCES);
      else
         nr = res_ff;
   end

   assign req_row      = PW'(req_process);
   assign req_in_range = 32'(req_process) < 32'(PROCESSES);
   assign slot_free    = !rsp_valid_ff || rsp_tready;
   assign accept       = req_tvalid && req_tready;

   // Per-lane amounts and column enables; merge of lane findings
   always_comb begin
      for (int r = 0; r < RESOURCES; r++) begin
         req_amt[r]     = AW'(req_amount[r]);
         lane_active[r] = 32'(r) < 32'(nr);
      end
      any_exceed = 1'b0;
      fits_all   = 1'b1;
      for (int r = 0; r < RESOURCES; r++) begin
         any_exceed = any_exceed | (lane_active[r] & lane_stat[r].exceeds);
         fits_all   = fits_all & (!lane_active[r] | lane_stat[r].fits);
      end
   end

   assign lane_amt = (state_ff == bsrc_pkg::ST_IDLE) ? req_amt : amt_ff;
   assign hit      = !done_ff[ptr_ff] && fits_all;

   // Next state and lane commands
   always_comb begin
      state_in   = state_ff;
      row_in     = row_ff;
      ptr_in     = ptr_ff;
      done_in    = done_ff;
      found_in   = found_ff;
      amt_in     = amt_ff;
      status_in  = status_ff;
      lane_op    = bsrc_pkg::LOP_NONE;
      lane_row   = row_ff;
      req_tready = 1'b0;
      rsp_load   = 1'b0;
      rsp_new    = bsrc_pkg::STAT_LOADED;
      case (state_ff)
         bsrc_pkg::ST_IDLE: begin
            // a request may enter while a result still waits
            req_tready = slot_free || (req_op == bsrc_pkg::OP_REQUEST);
            lane_row   = req_row;
            if (accept) begin
               case (bsrc_pkg::op_type'(req_op))
                  bsrc_pkg::OP_LOAD_MAX: begin
                     if (req_in_range) lane_op = bsrc_pkg::LOP_LOAD_MAX;
                     rsp_load = 1'b1;
                  end
                  bsrc_pkg::OP_LOAD_ALLOC: begin
                     if (req_in_range) lane_op = bsrc_pkg::LOP_LOAD_ALLOC;
                     rsp_load = 1'b1;
                  end
                  bsrc_pkg::OP_SET_AVAIL: begin
                     lane_op  = bsrc_pkg::LOP_LOAD_AVAIL;
                     rsp_load = 1'b1;
                  end
                  default: begin
                     row_in = req_row;
                     amt_in = req_amt;
                     if (32'(req_process) >= 32'(np)) begin
                        status_in = bsrc_pkg::STAT_EXCEEDS;
                        state_in  = bsrc_pkg::ST_RESULT;
                     end else begin
                        state_in = bsrc_pkg::ST_CHECK;
                     end
                  end
               endcase
            end
         end
         bsrc_pkg::ST_CHECK: begin
            if (any_exceed) begin
               status_in = bsrc_pkg::STAT_EXCEEDS;
               state_in  = bsrc_pkg::ST_RESULT;
            end else begin
               // tentative grant, then scan with inactive rows already done
               lane_op = bsrc_pkg::LOP_GRANT;
               for (int i = 0; i < PROCESSES; i++)
                  done_in[i] = 32'(i) >= 32'(np);
               ptr_in   = '0;
               found_in = 1'b0;
               state_in = bsrc_pkg::ST_SCAN;
            end
         end
         bsrc_pkg::ST_SCAN: begin
            lane_row = ptr_ff;
            if (hit) begin
               lane_op         = bsrc_pkg::LOP_RELEASE;
               done_in[ptr_ff] = 1'b1;
            end
            if (&done_in) begin
               state_in = bsrc_pkg::ST_DECIDE;
            end else if (ptr_ff == PW'(PROCESSES - 1)) begin
               // end of a pass: repeat only if something was released
               if (found_ff || hit) begin
                  ptr_in   = '0;
                  found_in = 1'b0;
               end else begin
                  state_in = bsrc_pkg::ST_DECIDE;
               end
            end else begin
               ptr_in   = ptr_ff + PW'(1);
               found_in = found_ff || hit;
            end
         end
         bsrc_pkg::ST_DECIDE: begin
            if (&done_ff) begin
               status_in = bsrc_pkg::STAT_GRANTED;
            end else begin
               lane_op   = bsrc_pkg::LOP_ROLLBACK;
               status_in = bsrc_pkg::STAT_UNSAFE;
            end
            state_in = bsrc_pkg::ST_RESULT;
         end
         bsrc_pkg::ST_RESULT: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               rsp_new  = status_ff;
               state_in = bsrc_pkg::ST_IDLE;
            end
         end
         default: state_in = bsrc_pkg::ST_IDLE;
      endcase
   end

   // Output register
   always_comb begin
      rsp_valid_in  = rsp_load || (rsp_valid_ff && !rsp_tready);
      rsp_status_in = rsp_load ? rsp_new : rsp_status_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsrc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         procs_ff     <= bsrc_pkg::PROCS_RESET;
         res_ff       <= bsrc_pkg::RES_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               bsrc_pkg::CSR_ACTIVE_PROCESSES: procs_ff <= csr_wdata;
               bsrc_pkg::CSR_ACTIVE_RESOURCES:
                  res_ff <= csr_wdata[bsrc_pkg::RES_REG_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      row_ff        <= row_in;
      ptr_ff        <= ptr_in;
      done_ff       <= done_in;
      found_ff      <= found_in;
      amt_ff        <= amt_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
   end

   // The finished set only grows during a scan
   a_done_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bsrc_pkg::ST_SCAN) |=> (($past(done_ff) & ~done_ff) == '0))
      else $error("finished process cleared during scan");

   // A load transfer yields a load-accepted result on the next cycle
   a_load_result: assert property (@(posedge clock) disable iff (reset)
      (accept && req_op != bsrc_pkg::OP_REQUEST) |=>
         (rsp_valid_ff && rsp_status_ff == bsrc_pkg::STAT_LOADED))
      else $error("load did not produce its result");

   // Pending request results are never load codes
   a_pending_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bsrc_pkg::ST_RESULT) |-> (status_ff != bsrc_pkg::STAT_LOADED))
      else $error("request result carries load status");

   // A grant is only decided when every process finished
   a_grant_safe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bsrc_pkg::ST_DECIDE && status_in == bsrc_pkg::STAT_GRANTED)
         |-> (&done_ff))
      else $error("grant without full finish set");

endmodule

`default_nettype wire

// ===== src/bankers_safety_request_check_core.sv =====
// Top level: banker's algorithm request checker with one lane per resource type.
// A load gives its result in the cycle after the transfer. A request beyond the
// active processes goes via ST_RESULT, one refused on need or available via
// ST_CHECK and ST_RESULT; a checked request adds the safety scan (one process per
// cycle, up to PROCESSES passes) and ST_DECIDE. One item in flight; a request is
// taken while a result waits, a load only once the result register frees up.
// Reset (synchronous, active high) clears both tables and the available vector.
`default_nettype none

module bankers_safety_request_check_core #(
   parameter int PROCESSES   = 8,
   parameter int RESOURCES   = 4,
   parameter int AMOUNT_BITS = 8
) (
   input  wire                                 clock,
   input  wire                                 reset,
   // request channel
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   // [2:0] process, [10:3] amount_0, [18:11] amount_1, [26:19] amount_2,
   // [34:27] amount_3, [39:35] zero
   input  wire [bsrc_pkg::REQ_DATA_W-1:0]      req_tdata,
   // [1:0] op
   input  wire [bsrc_pkg::OP_W-1:0]            req_tuser,
   // response channel
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   // [1:0] status, [7:2] zero
   output logic [bsrc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // configuration writes
   input  wire                                 csr_wr_en,
   input  wire [bsrc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire [bsrc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int PW = $clog2(PROCESSES);

   logic [bsrc_pkg::PROCESS_W-1:0]                                   req_process;
   logic [bsrc_pkg::AMOUNT_FIELDS-1:0][bsrc_pkg::AMOUNT_FIELD_W-1:0] req_amount;
   bsrc_pkg::status_type                                             rsp_status;
   bsrc_pkg::lane_op_type                                            lane_op;
   logic [PW-1:0]                                                    lane_row;
   logic [RESOURCES-1:0][AMOUNT_BITS-1:0]                            lane_amt;
   logic [RESOURCES-1:0]                                             lane_active;
   bsrc_pkg::lane_stat_type [RESOURCES-1:0]                          lane_stat;

   // Unpack the request payload
   always_comb begin
      req_process = req_tdata[bsrc_pkg::PROCESS_W-1:0];
      for (int k = 0; k < bsrc_pkg::AMOUNT_FIELDS; k++)
         req_amount[k] = req_tdata[bsrc_pkg::PROCESS_W + k*bsrc_pkg::AMOUNT_FIELD_W
                                   +: bsrc_pkg::AMOUNT_FIELD_W];
   end

   assign rsp_tdata = {{(bsrc_pkg::RSP_DATA_W - bsrc_pkg::STATUS_W){1'b0}}, rsp_status};

   bsrc_ctrl #(
      .PROCESSES   (PROCESSES),
      .RESOURCES   (RESOURCES),
      .AMOUNT_BITS (AMOUNT_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_op      (req_tuser),
      .req_process (req_process),
      .req_amount  (req_amount),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_status  (rsp_status),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .lane_op     (lane_op),
      .lane_row    (lane_row),
      .lane_amt    (lane_amt),
      .lane_active (lane_active),
      .lane_stat   (lane_stat)
   );

   // One lane per resource type
   for (genvar r = 0; r < RESOURCES; r++) begin : g_lane
      bsrc_lane #(
         .PROCESSES   (PROCESSES),
         .AMOUNT_BITS (AMOUNT_BITS)
      ) u_lane (
         .clock      (clock),
         .reset      (reset),
         .lane_op    (lane_op),
         .row        (lane_row),
         .amount     (lane_amt[r]),
         .col_active (lane_active[r]),
         .stat       (lane_stat[r])
      );
   end

endmodule

`default_nettype wire
